@@ rtl/hkm_pkg.sv @@
// Shared types and constants for the key to dense identifier mapper.
package hkm_pkg;

    // Fixed field widths.
    localparam int KEY_W = 31;

    // Input opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Kind of result that the controller asks the datapath to commit.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CLEAR = 2'd0;
    localparam t_kind KIND_HIT   = 2'd1;
    localparam t_kind KIND_MISS  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;          // capture the accepted item
        logic  rd_head;       // read the bucket head pointer
        logic  rd_from_head;  // read the pool entry named by the head pointer
        logic  rd_from_next;  // read the pool entry named by the next link
        logic  mark_head;     // the bucket head belongs to the current map
        logic  commit;        // update state and load the result register
        t_kind kind;          // what to commit
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_clear;      // the offered item is a clear
        logic head_live;     // head pointer is below the entry count
        logic key_hit;       // entry just read holds the key
        logic bucket_match;  // entry just read lies in the key's bucket
        logic chain_end;     // entry just read ends its chain
        logic first;         // entry just read is the chain head
        logic out_free;      // result register can take a new result
    } t_status;

endpackage

@@ rtl/hkm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module hkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/hkm_dp.sv @@
// Datapath of the mapper: bucket head and entry pool memories, entry count, result register.
module hkm_dp
    import hkm_pkg::*;
#(
    parameter int BUCKET_BITS = 12,
    parameter int POOL_DEPTH  = 4096,
    localparam int IDX_W = $clog2(POOL_DEPTH),
    localparam int CNT_W = IDX_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_opcode,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_out_stall,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_out_valid,
    output logic [CNT_W-1:0] o_ident,
    output logic             o_is_new,
    output logic             o_full_res
);

    localparam int ENT_W = KEY_W + CNT_W;

    logic [KEY_W-1:0]       r_key;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_head;
    logic                   r_head_ok;
    logic                   r_first;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_ident;
    logic                   r_is_new;
    logic                   r_full_res;

    logic [BUCKET_BITS-1:0] w_bucket;
    logic [IDX_W-1:0]       w_head_q;
    logic [ENT_W-1:0]       w_ent_q;
    logic [KEY_W-1:0]       w_ent_key;
    logic [CNT_W-1:0]       w_ent_next;
    logic [CNT_W-1:0]       w_next_m1;
    logic [IDX_W-1:0]       w_ent_rd_addr;
    logic                   w_ent_rd_en;
    logic                   w_pool_full;
    logic                   w_insert;
    logic [CNT_W-1:0]       w_new_next;

    assign w_bucket    = r_key[BUCKET_BITS-1:0];
    assign w_ent_key   = w_ent_q[ENT_W-1:CNT_W];
    assign w_ent_next  = w_ent_q[CNT_W-1:0];
    assign w_next_m1   = w_ent_next - CNT_W'(1);
    assign w_pool_full = (r_count == CNT_W'(POOL_DEPTH));

    // Pool entry read address: chain head first, then each next link.
    assign w_ent_rd_en   = i_cmd.rd_from_head | i_cmd.rd_from_next;
    assign w_ent_rd_addr = i_cmd.rd_from_head ? w_head_q : w_next_m1[IDX_W-1:0];

    // A new key goes to the head of its chain and links to the old head if that is live and lies in its bucket.
    assign w_insert   = i_cmd.commit && (i_cmd.kind == KIND_MISS) && !w_pool_full;
    assign w_new_next = r_head_ok ? ({1'b0, r_head} + CNT_W'(1)) : '0;

    // Bucket head pointers.
    hkm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (2 ** BUCKET_BITS)
    ) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_insert),
        .i_wr_addr (w_bucket),
        .i_wr_data (r_count[IDX_W-1:0]),
        .i_rd_en   (i_cmd.rd_head),
        .i_rd_addr (w_bucket),
        .o_rd_data (w_head_q)
    );

    // Entry pool: key and next link of each entry.
    hkm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (POOL_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_insert),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({r_key, w_new_next}),
        .i_rd_en   (w_ent_rd_en),
        .i_rd_addr (w_ent_rd_addr),
        .o_rd_data (w_ent_q)
    );

    // Item capture and chain walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_key;
            r_head_ok <= 1'b0;
        end
        if (i_cmd.rd_from_head) begin
            r_head  <= w_head_q;
            r_idx   <= w_head_q;
            r_first <= 1'b1;
        end
        if (i_cmd.rd_from_next) begin
            r_idx   <= w_next_m1[IDX_W-1:0];
            r_first <= 1'b0;
        end
        if (i_cmd.mark_head) begin
            r_head_ok <= 1'b1;
        end
    end

    // Entry count: a clear empties the map, an insert takes the next entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit && (i_cmd.kind == KIND_CLEAR)) begin
            r_count <= '0;
        end else if (w_insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            unique case (i_cmd.kind)
                KIND_HIT: begin
                    r_ident    <= {1'b0, r_idx} + CNT_W'(1);
                    r_is_new   <= 1'b0;
                    r_full_res <= 1'b0;
                end
                KIND_MISS: begin
                    r_ident    <= w_pool_full ? '0 : (r_count + CNT_W'(1));
                    r_is_new   <= !w_pool_full;
                    r_full_res <= w_pool_full;
                end
                default: begin
                    r_ident    <= '0;
                    r_is_new   <= 1'b0;
                    r_full_res <= 1'b0;
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.in_clear     = (i_opcode == OP_CLEAR);
        o_status.head_live    = ({1'b0, w_head_q} < r_count);
        o_status.key_hit      = (w_ent_key == r_key);
        o_status.bucket_match = (w_ent_key[BUCKET_BITS-1:0] == w_bucket);
        o_status.chain_end    = (w_ent_next == '0);
        o_status.first        = r_first;
        o_status.out_free     = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_ident     = r_ident;
    assign o_is_new    = r_is_new;
    assign o_full_res  = r_full_res;

endmodule

@@ rtl/hkm_ctrl.sv @@
// Controller state machine of the mapper: item accept, chain walk sequencing, result commit.
module hkm_ctrl
    import hkm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_RD_HEAD   = 3'd1;
    localparam logic [2:0] S_CHK_HEAD  = 3'd2;
    localparam logic [2:0] S_CHK_ENTRY = 3'd3;
    localparam logic [2:0] S_FIN       = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_kind      r_kind;
    t_kind      n_kind;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_clear) begin
                        n_kind  = KIND_CLEAR;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RD_HEAD;
                    end
                end
            end
            S_RD_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_CHK_HEAD;
            end
            S_CHK_HEAD: begin
                // A head pointer at or above the entry count is stale.
                if (i_status.head_live) begin
                    o_cmd.rd_from_head = 1'b1;
                    n_state            = S_CHK_ENTRY;
                end else begin
                    n_kind  = KIND_MISS;
                    n_state = S_FIN;
                end
            end
            S_CHK_ENTRY: begin
                // A live head is current only if its entry lies in this bucket.
                o_cmd.mark_head = i_status.first && i_status.bucket_match;
                priority if (i_status.key_hit) begin
                    n_kind  = KIND_HIT;
                    n_state = S_FIN;
                end else if (i_status.first && !i_status.bucket_match) begin
                    n_kind  = KIND_MISS;
                    n_state = S_FIN;
                end else if (i_status.chain_end) begin
                    n_kind  = KIND_MISS;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_from_next = 1'b1;
                end
            end
            S_FIN: begin
                // Commit once the result register has room.
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_CLEAR;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/hash_key_to_dense_id_mapper_top.sv @@
// A lookup or insert reads the bucket head, checks it, then visits the bucket's chain entries
// one by one before the result is committed; a clear goes straight to the commit.
// Throughput: one item at a time; the chain walk through the entry pool RAM, one entry per
// cycle, sets the rate. A full result register delays the commit until it drains.
// Reset is synchronous and clears the entry count and control; the memories are not swept,
// and a bucket counts as filled only if its head is below the count and lies in that bucket.
module hash_key_to_dense_id_mapper_top
    import hkm_pkg::*;
#(
    parameter int BUCKET_BITS = 12,
    parameter int POOL_DEPTH  = 4096,
    localparam int CNT_W = $clog2(POOL_DEPTH) + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_opcode,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [CNT_W-1:0] o_ident,
    output logic             o_is_new,
    output logic             o_full_res
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    hkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Memories, count and result register.
    hkm_dp #(
        .BUCKET_BITS (BUCKET_BITS),
        .POOL_DEPTH  (POOL_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_ident     (o_ident),
        .o_is_new    (o_is_new),
        .o_full_res  (o_full_res)
    );

endmodule
